>>> src/kdh_pkg.sv
// Shared types and constants for the key debounce and hold detector.
`timescale 1ns / 1ps
`default_nettype none
package kdh_pkg;

    localparam int KEY_W          = 5;
    localparam int NOW_W          = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int NUM_KEYS_DEF   = 32;
    localparam int TIME_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RST       = 16'd500;
    localparam logic [KEY_W-1:0] SHORT_KEY_RST  = 5'd26;
    localparam logic [CFG_W-1:0] SHORT_HOLD_RST = 16'd200;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HOLD     = 2'd2
    } key_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE       = 2'd0,
        CFG_HOLD           = 2'd1,
        CFG_SHORT_KEY      = 2'd2,
        CFG_SHORT_HOLD     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             raw_level;
        logic [NOW_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic [1:0]       key_state;
        logic [1:0]       last_state;
        logic             changed;
    } result_t;

    // Per-key status bits kept next to the two timestamps.
    typedef struct packed {
        logic       last_raw;
        key_state_t dstate;
        key_state_t earlier;
        logic       settling;
    } kdh_flags_t;

    localparam kdh_flags_t FLAGS_RST = '{
        last_raw: 1'b1,
        dstate:   ST_RELEASED,
        earlier:  ST_RELEASED,
        settling: 1'b0
    };

endpackage
`default_nettype wire

>>> src/kdh_rec_mem.sv
// Per-key record memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module kdh_rec_mem #(
    parameter int NUM_KEYS   = kdh_pkg::NUM_KEYS_DEF,
    parameter int TIME_WIDTH = kdh_pkg::TIME_WIDTH_DEF,
    parameter int AW         = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rd_en,
    input  wire logic [AW-1:0]          rd_addr,
    output kdh_pkg::kdh_flags_t         rd_flags,
    output logic [TIME_WIDTH-1:0]       rd_change,
    output logic [TIME_WIDTH-1:0]       rd_press,
    input  wire logic                   wr_en,
    input  wire logic [AW-1:0]          wr_addr,
    input  kdh_pkg::kdh_flags_t         wr_flags,
    input  wire logic [TIME_WIDTH-1:0]  wr_change,
    input  wire logic [TIME_WIDTH-1:0]  wr_press
);
    import kdh_pkg::*;

    kdh_flags_t            flags_mem  [NUM_KEYS];
    logic [TIME_WIDTH-1:0] change_mem [NUM_KEYS];
    logic [TIME_WIDTH-1:0] press_mem  [NUM_KEYS];

    logic [NUM_KEYS-1:0]   valid_reg;
    logic                  rd_valid_reg;
    kdh_flags_t            rd_flags_reg;
    logic [TIME_WIDTH-1:0] rd_change_reg;
    logic [TIME_WIDTH-1:0] rd_press_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flags_mem[wr_addr]  <= wr_flags;
            change_mem[wr_addr] <= wr_change;
            press_mem[wr_addr]  <= wr_press;
        end
        if (rd_en)
        begin
            rd_flags_reg  <= flags_mem[rd_addr];
            rd_change_reg <= change_mem[rd_addr];
            rd_press_reg  <= press_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset record
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_flags  = rd_flags_reg;
            rd_change = rd_change_reg;
            rd_press  = rd_press_reg;
        end
        else
        begin
            rd_flags  = FLAGS_RST;
            rd_change = '0;
            rd_press  = '0;
        end
    end

endmodule
`default_nettype wire

>>> src/kdh_update.sv
// Debounce and hold update of one key record for one sample.
`timescale 1ns / 1ps
`default_nettype none
module kdh_update #(
    parameter int TIME_WIDTH = kdh_pkg::TIME_WIDTH_DEF
) (
    input  kdh_pkg::kdh_flags_t                 flags,
    input  wire logic [TIME_WIDTH-1:0]          change_time,
    input  wire logic [TIME_WIDTH-1:0]          press_time,
    input  wire logic                           raw,
    input  wire logic [TIME_WIDTH-1:0]          now,
    input  wire logic [kdh_pkg::CFG_W-1:0]      debounce,
    input  wire logic [kdh_pkg::CFG_W-1:0]      hold_limit,
    output kdh_pkg::kdh_flags_t                 flags_new,
    output logic [TIME_WIDTH-1:0]               change_new,
    output logic [TIME_WIDTH-1:0]               press_new,
    output logic                                changed
);
    import kdh_pkg::*;

    logic [TIME_WIDTH-1:0] el_change;
    logic [TIME_WIDTH-1:0] el_press;
    logic                  raw_chg;
    logic                  settle;
    logic                  new_press;

    assign el_change = now - change_time;
    assign el_press  = now - press_time;
    assign raw_chg   = raw != flags.last_raw;
    // a fresh level change restarts the timer at zero, so it cannot settle now
    assign settle    = flags.settling && !raw_chg
                       && (el_change > TIME_WIDTH'(debounce));
    assign new_press = settle && !raw && (flags.dstate == ST_RELEASED);

    always_comb
    begin
        flags_new          = flags;
        flags_new.last_raw = raw;
        change_new         = change_time;
        press_new          = press_time;
        changed            = 1'b0;

        if (raw_chg)
        begin
            change_new         = now;
            flags_new.settling = 1'b1;
        end

        if (settle)
        begin
            flags_new.earlier  = flags.dstate;
            flags_new.settling = 1'b0;
            if (new_press)
            begin
                flags_new.dstate = ST_PRESSED;
                press_new        = now;
                changed          = 1'b1;
            end
            else if (raw)
            begin
                flags_new.dstate = ST_RELEASED;
                changed          = 1'b1;
            end
        end

        // a press taken in this sample has zero elapsed time and cannot hold
        if ((flags_new.dstate == ST_PRESSED) && !new_press
            && (el_press > TIME_WIDTH'(hold_limit)))
        begin
            flags_new.earlier = ST_PRESSED;
            flags_new.dstate  = ST_HOLD;
            changed           = 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> src/key_debounce_hold_detect.sv
// Top level: per-key debouncer with press and hold detection.
// Pipeline: an accepted sample beat is registered in s1, and its result is then
// registered into the result register, where it is held until taken as a result beat.
// Throughput: one sample per cycle unless a result stalls; the record memory port pair
// and write-to-read forwarding let consecutive samples of the same key follow directly.
// Reset: asynchronous active-low; config registers return to defaults and all key
// records read as released through per-entry valid bits, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module key_debounce_hold_detect #(
    parameter int NUM_KEYS   = kdh_pkg::NUM_KEYS_DEF,
    parameter int TIME_WIDTH = kdh_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [kdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kdh_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           sample_valid,
    output logic                                sample_ready,
    input  kdh_pkg::sample_t                    sample,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output kdh_pkg::result_t                    result
);
    import kdh_pkg::*;

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] hold_reg;
    logic [KEY_W-1:0] short_key_reg;
    logic [CFG_W-1:0] short_hold_reg;

    logic             s1_valid_reg;
    sample_t          s1_item_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic                  wr_valid_reg;
    logic [AW-1:0]         wr_addr_reg;
    kdh_flags_t            wr_flags_reg;
    logic [TIME_WIDTH-1:0] wr_change_reg;
    logic [TIME_WIDTH-1:0] wr_press_reg;

    logic                  accept;
    logic                  in_range;
    logic                  s1_in_range;
    logic                  s1_adv;
    logic                  wr_en;
    logic [AW-1:0]         s1_addr;
    logic                  fwd;
    kdh_flags_t            mem_flags;
    logic [TIME_WIDTH-1:0] mem_change;
    logic [TIME_WIDTH-1:0] mem_press;
    kdh_flags_t            cur_flags;
    logic [TIME_WIDTH-1:0] cur_change;
    logic [TIME_WIDTH-1:0] cur_press;
    kdh_flags_t            new_flags;
    logic [TIME_WIDTH-1:0] new_change;
    logic [TIME_WIDTH-1:0] new_press;
    logic                  upd;
    logic [CFG_W-1:0]      hold_limit;
    result_t               result_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            hold_reg       <= HOLD_RST;
            short_key_reg  <= SHORT_KEY_RST;
            short_hold_reg <= SHORT_HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_HOLD:       hold_reg       <= cfg_data;
                CFG_SHORT_KEY:  short_key_reg  <= cfg_data[KEY_W-1:0];
                CFG_SHORT_HOLD: short_hold_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // handshake and pipeline control
    assign s1_adv       = !result_valid_reg || result_ready;
    assign sample_ready = !s1_valid_reg || s1_adv;
    assign accept       = sample_valid && sample_ready;
    assign in_range     = 32'(sample.key_index) < NUM_KEYS;
    assign s1_in_range  = 32'(s1_item_reg.key_index) < NUM_KEYS;
    assign s1_addr      = AW'(s1_item_reg.key_index);
    assign wr_en        = s1_valid_reg && s1_adv && s1_in_range;

    kdh_rec_mem #(
        .NUM_KEYS   (NUM_KEYS),
        .TIME_WIDTH (TIME_WIDTH),
        .AW         (AW)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept && in_range),
        .rd_addr   (AW'(sample.key_index)),
        .rd_flags  (mem_flags),
        .rd_change (mem_change),
        .rd_press  (mem_press),
        .wr_en     (wr_en),
        .wr_addr   (s1_addr),
        .wr_flags  (new_flags),
        .wr_change (new_change),
        .wr_press  (new_press)
    );

    // the latest write to this key may not be visible in the read data yet
    assign fwd        = wr_valid_reg && (wr_addr_reg == s1_addr);
    assign cur_flags  = fwd ? wr_flags_reg  : mem_flags;
    assign cur_change = fwd ? wr_change_reg : mem_change;
    assign cur_press  = fwd ? wr_press_reg  : mem_press;
    assign hold_limit = (s1_item_reg.key_index == short_key_reg) ? short_hold_reg : hold_reg;

    kdh_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_upd (
        .flags       (cur_flags),
        .change_time (cur_change),
        .press_time  (cur_press),
        .raw         (s1_item_reg.raw_level),
        .now         (TIME_WIDTH'(s1_item_reg.now_ms)),
        .debounce    (debounce_reg),
        .hold_limit  (hold_limit),
        .flags_new   (new_flags),
        .change_new  (new_change),
        .press_new   (new_press),
        .changed     (upd)
    );

    always_comb
    begin
        result_next.key_id = s1_item_reg.key_index;
        if (s1_in_range)
        begin
            result_next.key_state  = new_flags.dstate;
            result_next.last_state = new_flags.earlier;
            result_next.changed    = upd;
        end
        else
        begin
            result_next.key_state  = ST_RELEASED;
            result_next.last_state = ST_RELEASED;
            result_next.changed    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            wr_valid_reg     <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s1_adv)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (wr_en)
            begin
                wr_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= sample;
        end
        if (s1_valid_reg && s1_adv)
        begin
            result_reg <= result_next;
        end
        if (wr_en)
        begin
            wr_addr_reg   <= s1_addr;
            wr_flags_reg  <= new_flags;
            wr_change_reg <= new_change;
            wr_press_reg  <= new_press;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

>>> src/kdh_checker.sv
// Port-level checker for the key debounce and hold detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kdh_checker #(
    parameter int NUM_KEYS = kdh_pkg::NUM_KEYS_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           sample_valid,
    input wire logic                           sample_ready,
    input wire logic                           result_valid,
    input wire logic                           result_ready,
    input kdh_pkg::result_t                    result
);
    import kdh_pkg::*;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // a new result beat follows an accepted sample beat through the s1 register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
        else $error("result beat without a matching sample beat");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (32'(result.key_id) >= NUM_KEYS)
        |-> (result.key_state == ST_RELEASED) && (result.last_state == ST_RELEASED)
            && !result.changed)
        else $error("out-of-range key reported a state");

    // hold is only reached from pressed
    a_hold_from_press: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.changed && (result.key_state == ST_HOLD)
        |-> result.last_state == ST_PRESSED)
        else $error("hold entered from a state other than pressed");

endmodule

bind key_debounce_hold_detect kdh_checker #(.NUM_KEYS(NUM_KEYS)) u_kdh_checker (.*);
`default_nettype wire

>>> tb/tb_key_debounce_hold_detect.sv
`timescale 1ns / 1ps
// Self-checking key debounce and hold detector bench: directed and random scans vs a predictor.
module tb_key_debounce_hold_detect;
    import kdh_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 150;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             cfg_we       = 1'b0;
    cfg_idx_t         cfg_index    = CFG_DEBOUNCE;
    logic [CFG_W-1:0] cfg_data     = '0;
    logic             sample_valid = 1'b0;
    logic             sample_ready;
    sample_t          sample       = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;

    key_debounce_hold_detect dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Predictor copy of the registers and per-key records
    logic [CFG_W-1:0] debounce_cfg;
    logic [CFG_W-1:0] hold_cfg;
    logic [KEY_W-1:0] short_key_cfg;
    logic [CFG_W-1:0] short_hold_cfg;
    logic             pin_seen  [NUM_KEYS_DEF];
    key_state_t       dstate    [NUM_KEYS_DEF];
    key_state_t       prior     [NUM_KEYS_DEF];
    logic             settling  [NUM_KEYS_DEF];
    logic [NOW_W-1:0] change_ms [NUM_KEYS_DEF];
    logic [NOW_W-1:0] press_ms  [NUM_KEYS_DEF];

    // Stimulus timeline per key
    logic [NOW_W-1:0] scan_ms   [NUM_KEYS_DEF];
    logic             scan_lvl  [NUM_KEYS_DEF];

    sample_t scan_queue[$];
    result_t report_queue[$];
    result_t want;
    int      n_queued    = 0;
    int      n_taken     = 0;
    int      errors      = 0;
    int      cycle_count = 0;
    int      stall_reqs  = 0;
    int      stall_seen  = 0;
    int      hold_left   = 0;
    bit      calm        = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t debounce_predict(input sample_t s);
        result_t          r;
        int               k;
        logic [NOW_W-1:0] age;
        logic [CFG_W-1:0] limit;
        logic             upd;
        k   = s.key_index;
        upd = 1'b0;
        if (s.raw_level != pin_seen[k])
        begin
            change_ms[k] = s.now_ms;
            settling[k]  = 1'b1;
        end
        age = s.now_ms - change_ms[k];
        if (settling[k] && age > debounce_cfg)
        begin
            prior[k] = dstate[k];
            if (!s.raw_level && dstate[k] == ST_RELEASED)
            begin
                dstate[k]   = ST_PRESSED;
                press_ms[k] = s.now_ms;
                upd         = 1'b1;
            end
            else if (s.raw_level)
            begin
                // a release is taken even when already released
                dstate[k] = ST_RELEASED;
                upd       = 1'b1;
            end
            settling[k] = 1'b0;
        end
        limit = (s.key_index == short_key_cfg) ? short_hold_cfg : hold_cfg;
        age   = s.now_ms - press_ms[k];
        if (dstate[k] == ST_PRESSED && age > limit)
        begin
            prior[k]  = ST_PRESSED;
            dstate[k] = ST_HOLD;
            upd       = 1'b1;
        end
        pin_seen[k]  = s.raw_level;
        r.key_id     = s.key_index;
        r.key_state  = dstate[k];
        r.last_state = prior[k];
        r.changed    = upd;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic add_sample(input logic [KEY_W-1:0] k, input logic lvl,
                              input logic [NOW_W-1:0] t);
        scan_queue.push_back('{key_index: k, raw_level: lvl, now_ms: t});
        n_queued++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            CFG_DEBOUNCE:   debounce_cfg   = v;
            CFG_HOLD:       hold_cfg       = v;
            CFG_SHORT_KEY:  short_key_cfg  = v[KEY_W-1:0];
            CFG_SHORT_HOLD: short_hold_cfg = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                            input logic [KEY_W-1:0] skey, input logic [CFG_W-1:0] shold);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_SHORT_KEY, {{(CFG_W-KEY_W){1'b0}}, skey});
        write_reg(CFG_SHORT_HOLD, shold);
    endtask

    // Gaps cluster on the debounce and hold boundaries, with an occasional wrap.
    function automatic logic [NOW_W-1:0] next_gap(input int k);
        logic [NOW_W-1:0] lim;
        int unsigned      r;
        lim = (k == short_key_cfg) ? short_hold_cfg : hold_cfg;
        r   = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 3);
        else if (r < 55)
            return debounce_cfg + $urandom_range(0, 1);
        else if (r < 75)
            return $urandom_range(0, debounce_cfg / 2 + 1);
        else if (r < 88)
            return lim + $urandom_range(0, 1);
        else if (r < 97)
            return $urandom_range(0, 2 * lim + 2);
        return $urandom;
    endfunction

    // Bursts on a few busy keys; level flips make bounces and real presses.
    task automatic random_bursts(input int n);
        int k;
        int len;
        int added;
        added = 0;
        while (added < n)
        begin
            case ($urandom_range(0, 9))
                0:       k = $urandom_range(0, NUM_KEYS_DEF - 1);
                1, 2, 3: k = short_key_cfg;
                default: k = $urandom_range(0, 3);
            endcase
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                if ($urandom_range(0, 5) == 0)
                    scan_lvl[k] = ~scan_lvl[k];
                scan_ms[k] = scan_ms[k] + next_gap(k);
                add_sample(KEY_W'(k), scan_lvl[k], scan_ms[k]);
                added++;
            end
        end
    endtask

    task automatic drain();
        while (n_taken != n_queued || report_queue.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Sender: a new beat goes out only once the previous one is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                report_queue.push_back(debounce_predict(sample));
                n_taken++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (scan_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 16))
                begin
                    sample       <= scan_queue.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (report_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got key %0d state %0d",
                             $time, result.key_id, result.key_state);
                    errors++;
                end
                else
                begin
                    want = report_queue.pop_front();
                    compare_field("key_id", want.key_id, result.key_id);
                    compare_field("key_state", want.key_state, result.key_state);
                    compare_field("last_state", want.last_state, result.last_state);
                    compare_field("changed", want.changed, result.changed);
                end
            end
            if (stall_seen != stall_reqs)
            begin
                stall_seen = stall_reqs;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= calm || $urandom_range(0, 99) >= 16;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("key_debounce_hold_detect regression: fail");
            $finish;
        end
    end

    initial
    begin
        debounce_cfg   = DEBOUNCE_RST;
        hold_cfg       = HOLD_RST;
        short_key_cfg  = SHORT_KEY_RST;
        short_hold_cfg = SHORT_HOLD_RST;
        for (int k = 0; k < NUM_KEYS_DEF; k++)
        begin
            pin_seen[k]  = 1'b1;
            dstate[k]    = ST_RELEASED;
            prior[k]     = ST_RELEASED;
            settling[k]  = 1'b0;
            change_ms[k] = '0;
            press_ms[k]  = '0;
            scan_ms[k]   = $urandom;
            scan_lvl[k]  = 1'b1;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // press, debounce boundary, hold boundary, release from hold
        add_sample(5'd0, 1'b1, 32'd0);
        add_sample(5'd0, 1'b0, 32'd100);
        add_sample(5'd0, 1'b0, 32'd120);
        add_sample(5'd0, 1'b0, 32'd121);
        add_sample(5'd0, 1'b0, 32'd621);
        add_sample(5'd0, 1'b0, 32'd622);
        add_sample(5'd0, 1'b1, 32'd700);
        add_sample(5'd0, 1'b1, 32'd721);
        // glitch while released settles into another release
        add_sample(5'd0, 1'b0, 32'd800);
        add_sample(5'd0, 1'b1, 32'd805);
        add_sample(5'd0, 1'b1, 32'd826);
        // short-hold key: press settling again while pressed, then short hold
        add_sample(5'd26, 1'b0, 32'd1000);
        add_sample(5'd26, 1'b0, 32'd1021);
        add_sample(5'd26, 1'b1, 32'd1030);
        add_sample(5'd26, 1'b0, 32'd1035);
        add_sample(5'd26, 1'b0, 32'd1056);
        add_sample(5'd26, 1'b0, 32'd1222);
        // timer wrap on the top key
        add_sample(5'd31, 1'b0, 32'hFFFF_FFF0);
        add_sample(5'd31, 1'b0, 32'h0000_0005);
        add_sample(5'd31, 1'b0, 32'hFFFF_FFFF);
        add_sample(5'd31, 1'b1, 32'h0000_0000);
        add_sample(5'd31, 1'b1, 32'h8000_0000);
        drain();

        random_bursts(PHASE_ITEMS);
        drain();

        set_regs(16'd0, 16'd0, 5'd0, 16'hFFFF);
        calm = 1'b1;
        random_bursts(PHASE_ITEMS);
        drain();
        calm = 1'b0;

        // long receiver hold-off while the sender keeps pushing
        set_regs(16'hFFFF, 16'hFFFF, 5'd31, 16'd0);
        random_bursts(PHASE_ITEMS);
        stall_reqs++;
        drain();

        set_regs(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 400)),
                 KEY_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 400)));
        random_bursts(PHASE_ITEMS);
        drain();

        set_regs(16'd3, 16'd40, KEY_W'($urandom_range(0, 31)), 16'd10);
        random_bursts(PHASE_ITEMS);
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("key_debounce_hold_detect regression: pass");
        else
            $display("key_debounce_hold_detect regression: fail");
        $finish;
    end

endmodule
